// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ugcc_pkg.sv
package ugcc_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int NODE_W        = 6;
    localparam int MODE_W        = 2;
    localparam int COUNT_W       = 7;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_SWEEP,
        ST_DRAIN,
        ST_HOLD
    } state_t;

endpackage

// File: rtl/ugcc_if.sv
interface ugcc_req_if;
    logic                          valid;
    logic                          ready;
    logic [ugcc_pkg::MODE_W-1:0]   mode;
    logic [ugcc_pkg::NODE_W-1:0]   node_a;
    logic [ugcc_pkg::NODE_W-1:0]   node_b;

    modport source (output valid, output mode, output node_a, output node_b, input ready);
    modport sink   (input valid, input mode, input node_a, input node_b, output ready);
endinterface

interface ugcc_res_if;
    logic                          valid;
    logic                          ready;
    logic                          connected;
    logic [ugcc_pkg::NODE_W-1:0]   first_unreached;

    modport source (output valid, output connected, output first_unreached, input ready);
    modport sink   (input valid, input connected, input first_unreached, output ready);
endinterface

interface ugcc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ugcc_pkg::COUNT_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ugcc_ram.sv
module ugcc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/undirected_graph_connectivity_checker_core.sv
// A request is taken only in ST_IDLE, so one is walked at a time. The walk sweeps the adjacency
// RAM S times, N = nodes in use (S <= N; the walk stops after a sweep that adds no node);
// one RAM row is read per cycle while sweeping.
// The result register frees the input side while a result waits to be taken.
// Reset (rst_n low, async): node_count = 64, every row flag cleared so the matrix
// reads as empty, no result pending.
`include "assert_macros.svh"

module undirected_graph_connectivity_checker_core #(
    parameter int MAX_NODES = ugcc_pkg::MAX_NODES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ugcc_req_if.sink     req,
    ugcc_res_if.source   res,
    ugcc_cfg_if.sink     cfg
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int NW = ugcc_pkg::NODE_W;

    ugcc_pkg::state_t st_reg, st_next;

    logic [ugcc_pkg::COUNT_W-1:0] node_count_reg;
    logic [CW-1:0]                cnt_reg, cnt_next, cnt_in;
    logic [NW-1:0]                lo_reg, lo_next, hi_reg, hi_next;
    logic                         wr_req_reg, wr_req_next;
    logic                         add_reg, add_next;
    logic [MAX_NODES-1:0]         seen_reg, seen_next;
    logic [AW-1:0]                issue_reg, issue_next;
    logic                         proc_valid_reg, proc_valid_next;
    logic [AW-1:0]                proc_addr_reg, proc_addr_next;
    logic                         changed_reg, changed_next;
    logic                         found_reg, found_next;
    logic [AW-1:0]                miss_reg, miss_next;
    logic [MAX_NODES-1:0]         row_valid_reg, row_valid_next;
    logic                         fin_conn_reg, fin_conn_next;
    logic [NW-1:0]                fin_miss_reg, fin_miss_next;
    logic                         res_valid_reg, res_valid_next;
    logic                         res_conn_reg, res_conn_next;
    logic [NW-1:0]                res_miss_reg, res_miss_next;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [MAX_NODES-1:0] ram_wdata, ram_rdata;

    logic [NW-1:0]        req_lo, req_hi, req_start;
    logic                 req_edge;
    logic [MAX_NODES-1:0] seen_init, walk_mask;
    logic [MAX_NODES-1:0] walk_row, walk_seen, rmw_row, hi_bit;
    logic                 walk_hit, walk_grow, issue_last;

    ugcc_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_adj_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign cfg.ready           = 1'b1;
    assign res.valid           = res_valid_reg;
    assign res.connected       = res_conn_reg;
    assign res.first_unreached = res_miss_reg;

    always_comb
    begin
        if (node_count_reg == '0)
        begin
            cnt_in = CW'(1);
        end
        else if (int'(node_count_reg) > MAX_NODES)
        begin
            cnt_in = CW'(MAX_NODES);
        end
        else
        begin
            cnt_in = CW'(node_count_reg);
        end
    end

    always_comb
    begin
        case (req.mode) inside
            ugcc_pkg::MODE_ADD, ugcc_pkg::MODE_REMOVE: req_edge = 1'b1;
            default:                                   req_edge = 1'b0;
        endcase
        req_lo    = (req.node_a < req.node_b) ? req.node_a : req.node_b;
        req_hi    = (req.node_a < req.node_b) ? req.node_b : req.node_a;
        req_start = req_edge ? req_lo : req.node_a;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            seen_init[i] = (32'(req_start) == 32'(i)) && (32'(req_start) < 32'(cnt_in));
            walk_mask[i] = 32'(i) < 32'(cnt_reg);
        end
    end

    // One row per cycle: a row joins the reached set if it was reached or touches it,
    // and then pulls in all its higher neighbors.
    assign walk_row   = row_valid_reg[proc_addr_reg] ? ram_rdata : '0;
    assign walk_hit   = seen_reg[proc_addr_reg] | (|(walk_row & walk_mask & seen_reg));
    assign walk_seen  = walk_hit ? (seen_reg | (walk_row & walk_mask)
                                    | (MAX_NODES'(1) << proc_addr_reg))
                                 : seen_reg;
    assign walk_grow  = walk_seen != seen_reg;
    assign issue_last = 32'(issue_reg) == (32'(cnt_reg) - 32'd1);

    assign rmw_row = row_valid_reg[AW'(lo_reg)] ? ram_rdata : '0;
    assign hi_bit  = MAX_NODES'(1) << hi_reg;

    always_comb
    begin
        st_next         = st_reg;
        cnt_next        = cnt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        wr_req_next     = wr_req_reg;
        add_next        = add_reg;
        seen_next       = seen_reg;
        issue_next      = issue_reg;
        proc_valid_next = 1'b0;
        proc_addr_next  = issue_reg;
        changed_next    = changed_reg;
        found_next      = found_reg;
        miss_next       = miss_reg;
        row_valid_next  = row_valid_reg;
        fin_conn_next   = fin_conn_reg;
        fin_miss_next   = fin_miss_reg;
        res_valid_next  = res_valid_reg;
        res_conn_next   = res_conn_reg;
        res_miss_next   = res_miss_reg;
        req.ready       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = AW'(lo_reg);
        ram_wdata       = add_reg ? (rmw_row | hi_bit) : (rmw_row & ~hi_bit);
        ram_re          = 1'b0;
        ram_raddr       = issue_reg;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        if (proc_valid_reg)
        begin
            seen_next    = walk_seen;
            changed_next = changed_reg | walk_grow;
            if (!walk_hit && !found_reg)
            begin
                found_next = 1'b1;
                miss_next  = proc_addr_reg;
            end
        end

        unique case (st_reg)
            ugcc_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    cnt_next    = cnt_in;
                    lo_next     = req_lo;
                    hi_next     = req_hi;
                    wr_req_next = req_edge && (32'(req_hi) < 32'(cnt_in));
                    add_next    = req.mode == ugcc_pkg::MODE_ADD;
                    seen_next   = seen_init;
                    st_next     = ugcc_pkg::ST_RD;
                end
            end
            ugcc_pkg::ST_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(lo_reg);
                st_next   = ugcc_pkg::ST_WR;
            end
            ugcc_pkg::ST_WR:
            begin
                if (wr_req_reg)
                begin
                    ram_we                      = 1'b1;
                    row_valid_next[AW'(lo_reg)] = 1'b1;
                end
                issue_next   = '0;
                changed_next = 1'b0;
                found_next   = 1'b0;
                st_next      = ugcc_pkg::ST_SWEEP;
            end
            ugcc_pkg::ST_SWEEP:
            begin
                ram_re          = 1'b1;
                proc_valid_next = 1'b1;
                proc_addr_next  = issue_reg;
                if (issue_last)
                begin
                    issue_next = '0;
                    st_next    = ugcc_pkg::ST_DRAIN;
                end
                else
                begin
                    issue_next = issue_reg + 1'b1;
                end
            end
            ugcc_pkg::ST_DRAIN:
            begin
                // last row of the sweep is processed here
                if (changed_reg || walk_grow)
                begin
                    changed_next = 1'b0;
                    found_next   = 1'b0;
                    st_next      = ugcc_pkg::ST_SWEEP;
                end
                else
                begin
                    fin_conn_next = found_reg || !walk_hit ? 1'b0 : 1'b1;
                    if (found_reg)
                    begin
                        fin_miss_next = NW'(miss_reg);
                    end
                    else if (!walk_hit)
                    begin
                        fin_miss_next = NW'(proc_addr_reg);
                    end
                    else
                    begin
                        fin_miss_next = '0;
                    end
                    st_next = ugcc_pkg::ST_HOLD;
                end
            end
            ugcc_pkg::ST_HOLD:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_conn_next  = fin_conn_reg;
                    res_miss_next  = fin_miss_reg;
                    st_next        = ugcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = ugcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= ugcc_pkg::ST_IDLE;
            node_count_reg <= ugcc_pkg::COUNT_RESET;
            proc_valid_reg <= 1'b0;
            row_valid_reg  <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            proc_valid_reg <= proc_valid_next;
            row_valid_reg  <= row_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                node_count_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        wr_req_reg    <= wr_req_next;
        add_reg       <= add_next;
        seen_reg      <= seen_next;
        issue_reg     <= issue_next;
        proc_addr_reg <= proc_addr_next;
        changed_reg   <= changed_next;
        found_reg     <= found_next;
        miss_reg      <= miss_next;
        fin_conn_reg  <= fin_conn_next;
        fin_miss_reg  <= fin_miss_next;
        res_conn_reg  <= res_conn_next;
        res_miss_reg  <= res_miss_next;
    end

    `ASSERT_NEXT(a_seen_monotone, clk, rst_n, proc_valid_reg, (seen_reg & $past(seen_reg)) == $past(seen_reg), "reached set lost a node during the walk")
    `ASSERT_IMPLIES(a_seen_in_use, clk, rst_n, (st_reg == ugcc_pkg::ST_SWEEP || st_reg == ugcc_pkg::ST_DRAIN), (seen_reg & ~walk_mask) == '0, "reached set holds a node outside the count")
    `ASSERT_IMPLIES(a_row_in_range, clk, rst_n, proc_valid_reg, 32'(proc_addr_reg) < 32'(cnt_reg), "processed row beyond node count")

endmodule
